FILE: design/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// types and constants shared by the packet resequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  localparam int SEQ_W      = 32;
  localparam int REF_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT = 2'd1;

  localparam logic [SEQ_W-1:0] FIRST_SEQ_RST = 32'd1;
  localparam logic [SEQ_W-1:0] SEQ_LIMIT_RST = 32'd0;

  typedef enum logic [0:0] {
    CMD_START  = 1'b0,
    CMD_PACKET = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'd0,
    ST_STASHED  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_DUP      = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_STARTED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASSIFY,
    S_STASH,
    S_DRAIN
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SEQ_W-1:0]  seq_num;
    logic [REF_W-1:0]  payload_ref;
  } in_pkt_t;

  typedef struct packed {
    status_t           status;
    logic [SEQ_W-1:0]  out_seq;
    logic [REF_W-1:0]  out_ref;
    logic              last;
    logic              complete;
  } out_pkt_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } shelf_ctl_t;

endpackage

`default_nettype wire

FILE: design/packet_resequencer.sv
// results: drops are decided in S_CLASSIFY, stash and release results follow the
//   registered shelf read; drained packets follow one per cycle unless stalled
// the input is not taken again until every result of the last packet is issued;
//   stash and release decisions wait on the registered read of the shelf memory
// a start command and reset each run a clearing pass over every shelf memory entry
//   with in_ready low; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// packet_resequencer
// reorder buffer for a numbered packet stream with a window shelf in memory
// ----------------------------------------------------------------------------
`default_nettype none

module packet_resequencer #(
  parameter int SHELF_DEPTH = 16,
  parameter int REF_WIDTH   = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire prs_pkg::in_pkt_t          in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output prs_pkg::out_pkt_t              out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [prs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDXW = (SHELF_DEPTH > 1) ? $clog2(SHELF_DEPTH) : 1;
  localparam int REFW = (REF_WIDTH < prs_pkg::REF_W) ? REF_WIDTH : prs_pkg::REF_W;

  prs_pkg::shelf_ctl_t shelf_ctl;
  logic [IDXW-1:0]     rd_addr;
  logic [IDXW-1:0]     wr_addr;
  logic [REFW-1:0]     wr_ref;
  logic                rd_valid;
  logic [REFW-1:0]     rd_ref;

  assign cfg_ready = 1'b1;

  prs_ctrl #(
    .DEPTH (SHELF_DEPTH),
    .IDXW  (IDXW),
    .REFW  (REFW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .shelf_ctl (shelf_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_ref    (wr_ref),
    .rd_valid  (rd_valid),
    .rd_ref    (rd_ref)
  );

  prs_shelf #(
    .DEPTH (SHELF_DEPTH),
    .IDXW  (IDXW),
    .REFW  (REFW)
  ) u_shelf (
    .clk      (clk),
    .ctl      (shelf_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_ref   (wr_ref),
    .rd_valid (rd_valid),
    .rd_ref   (rd_ref)
  );

endmodule

`default_nettype wire

FILE: design/prs_shelf.sv
// ----------------------------------------------------------------------------
// prs_shelf
// window shelf memory: one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prs_shelf #(
  parameter int DEPTH = 16,
  parameter int IDXW  = 4,
  parameter int REFW  = 16
) (
  input  wire                      clk,
  input  wire prs_pkg::shelf_ctl_t ctl,
  input  wire [IDXW-1:0]           rd_addr,
  input  wire [IDXW-1:0]           wr_addr,
  input  wire [REFW-1:0]           wr_ref,
  output logic                     rd_valid,
  output logic [REFW-1:0]          rd_ref
);

  logic [REFW:0] mem [DEPTH];
  logic [REFW:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {ctl.wr_valid, wr_ref};
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_valid = rd_data_r[REFW];
  assign rd_ref   = rd_data_r[REFW-1:0];

endmodule

`default_nettype wire

FILE: design/prs_ctrl.sv
// ----------------------------------------------------------------------------
// prs_ctrl
// classification, shelf sequencing, configuration registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module prs_ctrl #(
  parameter int DEPTH = 16,
  parameter int IDXW  = 4,
  parameter int REFW  = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire prs_pkg::in_pkt_t              in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output prs_pkg::out_pkt_t                  out_data,
  input  wire                                cfg_valid,
  input  wire [prs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [prs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output prs_pkg::shelf_ctl_t                shelf_ctl,
  output logic [IDXW-1:0]                    rd_addr,
  output logic [IDXW-1:0]                    wr_addr,
  output logic [REFW-1:0]                    wr_ref,
  input  wire                                rd_valid,
  input  wire [REFW-1:0]                     rd_ref
);

  localparam logic [prs_pkg::SEQ_W-1:0] DEPTH_SEQ = prs_pkg::SEQ_W'(DEPTH);
  localparam logic [IDXW:0]             DEPTH_EXT = (IDXW+1)'(DEPTH);
  localparam logic [IDXW-1:0]           LAST_IDX  = IDXW'(DEPTH - 1);

  prs_pkg::state_t                 state_r, state_nxt;
  logic [prs_pkg::SEQ_W-1:0]       ne_r, ne_nxt;
  logic [IDXW-1:0]                 head_r, head_nxt;
  logic [IDXW-1:0]                 clr_idx_r, clr_idx_nxt;
  logic [prs_pkg::SEQ_W-1:0]       first_seq_r, first_seq_nxt;
  logic [prs_pkg::SEQ_W-1:0]       seq_limit_r, seq_limit_nxt;
  logic                            out_valid_r, out_valid_nxt;
  prs_pkg::out_pkt_t               out_data_r, out_data_nxt;
  prs_pkg::in_pkt_t                item_r, item_nxt;
  logic [prs_pkg::SEQ_W-1:0]       pend_seq_r, pend_seq_nxt;
  logic [REFW-1:0]                 pend_ref_r, pend_ref_nxt;
  logic [IDXW-1:0]                 stash_slot_r, stash_slot_nxt;

  logic                            can_emit;
  logic                            emit;
  prs_pkg::out_pkt_t               emit_data;
  logic [prs_pkg::SEQ_W-1:0]       diff;
  logic                            in_range, is_lt, is_eq, is_far;
  logic [IDXW:0]                   slot_sum;
  logic [IDXW-1:0]                 slot;
  logic [IDXW-1:0]                 head_inc;
  logic [IDXW-1:0]                 clr_inc;
  logic                            done_now;
  logic [REFW-1:0]                 item_ref;

  assign can_emit = !out_valid_r || out_ready;
  assign diff     = item_r.seq_num - ne_r;
  assign in_range = (item_r.seq_num >= first_seq_r) && (item_r.seq_num < seq_limit_r);
  assign is_lt    = item_r.seq_num < ne_r;
  assign is_eq    = item_r.seq_num == ne_r;
  assign is_far   = diff >= DEPTH_SEQ;
  assign slot_sum = {1'b0, head_r} + {1'b0, diff[IDXW-1:0]};
  assign slot     = (slot_sum >= DEPTH_EXT) ? IDXW'(slot_sum - DEPTH_EXT) : slot_sum[IDXW-1:0];
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign clr_inc  = (clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + 1'b1;
  assign done_now = ne_r >= seq_limit_r;
  assign item_ref = item_r.payload_ref[REFW-1:0];

  // configuration writes
  always_comb begin
    first_seq_nxt = first_seq_r;
    seq_limit_nxt = seq_limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        prs_pkg::REG_FIRST_SEQ: first_seq_nxt = cfg_wdata;
        prs_pkg::REG_SEQ_LIMIT: seq_limit_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt          = state_r;
    ne_nxt             = ne_r;
    head_nxt           = head_r;
    clr_idx_nxt        = clr_idx_r;
    item_nxt           = item_r;
    pend_seq_nxt       = pend_seq_r;
    pend_ref_nxt       = pend_ref_r;
    stash_slot_nxt     = stash_slot_r;
    in_ready           = 1'b0;
    emit               = 1'b0;
    emit_data          = '0;
    emit_data.complete = done_now;
    emit_data.last     = 1'b1;
    shelf_ctl          = '0;
    rd_addr            = head_inc;
    wr_addr            = head_r;
    wr_ref             = item_ref;

    case (state_r)
      prs_pkg::S_CLEAR: begin
        shelf_ctl.wr_en = 1'b1;
        wr_addr         = clr_idx_r;
        clr_idx_nxt     = clr_inc;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = prs_pkg::S_IDLE;
        end
      end
      prs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = prs_pkg::S_CLASSIFY;
        end
      end
      prs_pkg::S_CLASSIFY: begin
        emit_data.out_seq = item_r.seq_num;
        if (item_r.cmd == prs_pkg::CMD_START) begin
          emit_data.status   = prs_pkg::ST_STARTED;
          emit_data.out_seq  = first_seq_r;
          emit_data.complete = first_seq_r >= seq_limit_r;
          if (can_emit) begin
            emit        = 1'b1;
            ne_nxt      = first_seq_r;
            head_nxt    = '0;
            clr_idx_nxt = '0;
            state_nxt   = prs_pkg::S_CLEAR;
          end
        end else if (!in_range || is_lt || (!is_eq && is_far)) begin
          if (!in_range) begin
            emit_data.status = prs_pkg::ST_RANGE;
          end else if (is_lt) begin
            emit_data.status = prs_pkg::ST_DUP;
          end else begin
            emit_data.status = prs_pkg::ST_OVERFLOW;
          end
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = prs_pkg::S_IDLE;
          end
        end else if (is_eq) begin
          pend_seq_nxt    = item_r.seq_num;
          pend_ref_nxt    = item_ref;
          ne_nxt          = ne_r + 1'b1;
          head_nxt        = head_inc;
          shelf_ctl.rd_en = 1'b1;
          rd_addr         = head_inc;
          state_nxt       = prs_pkg::S_DRAIN;
        end else begin
          shelf_ctl.rd_en = 1'b1;
          rd_addr         = slot;
          stash_slot_nxt  = slot;
          state_nxt       = prs_pkg::S_STASH;
        end
      end
      prs_pkg::S_STASH: begin
        emit_data.out_seq = item_r.seq_num;
        emit_data.status  = rd_valid ? prs_pkg::ST_DUP : prs_pkg::ST_STASHED;
        wr_addr           = stash_slot_r;
        if (can_emit) begin
          emit               = 1'b1;
          shelf_ctl.wr_en    = !rd_valid;
          shelf_ctl.wr_valid = 1'b1;
          state_nxt          = prs_pkg::S_IDLE;
        end
      end
      prs_pkg::S_DRAIN: begin
        emit_data.status  = prs_pkg::ST_RELEASED;
        emit_data.out_seq = pend_seq_r;
        emit_data.out_ref = prs_pkg::REF_W'(pend_ref_r);
        emit_data.last    = !rd_valid;
        if (can_emit) begin
          emit = 1'b1;
          if (rd_valid) begin
            // take the next consecutive entry off the shelf
            pend_seq_nxt    = ne_r;
            pend_ref_nxt    = rd_ref;
            ne_nxt          = ne_r + 1'b1;
            head_nxt        = head_inc;
            shelf_ctl.wr_en = 1'b1;
            wr_addr         = head_r;
            shelf_ctl.rd_en = 1'b1;
            rd_addr         = head_inc;
          end else begin
            state_nxt = prs_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = prs_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prs_pkg::S_CLEAR;
      ne_r        <= '0;
      head_r      <= '0;
      clr_idx_r   <= '0;
      first_seq_r <= prs_pkg::FIRST_SEQ_RST;
      seq_limit_r <= prs_pkg::SEQ_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      head_r      <= head_nxt;
      clr_idx_r   <= clr_idx_nxt;
      first_seq_r <= first_seq_nxt;
      seq_limit_r <= seq_limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    item_r       <= item_nxt;
    pend_seq_r   <= pend_seq_nxt;
    pend_ref_r   <= pend_ref_nxt;
    stash_slot_r <= stash_slot_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: design/prs_checker.sv
// ----------------------------------------------------------------------------
// prs_checker
// port-level checks on the packet resequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire prs_pkg::in_pkt_t          in_data,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire prs_pkg::out_pkt_t         out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a release can be followed by more results of the same transaction
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != prs_pkg::ST_RELEASED |-> out_data.last)
    else $error("non-release result without last");

  a_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != prs_pkg::ST_RELEASED |-> out_data.out_ref == '0)
    else $error("payload handle on non-release result");

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == prs_pkg::CMD_START |=> !in_ready)
    else $error("input taken right after start");

endmodule

bind packet_resequencer prs_checker u_prs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the packet resequencer: queued driver, monitor and
// predictor, directed opening then random sessions under varied idling
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SHELF_DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  prs_pkg::in_pkt_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  prs_pkg::out_pkt_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  prs_pkg::in_pkt_t pending_pkts[$];
  prs_pkg::out_pkt_t due_results[$];
  logic in_taken = 1'b0;
  int items_sent = 0;
  int errors = 0;
  int cycle_count = 0;
  int src_idle_pct = 23;
  int snk_idle_pct = 59;
  logic hold_armed = 1'b0;
  int hold_count = 0;

  logic [31:0] first_seq_cfg = prs_pkg::FIRST_SEQ_RST;
  logic [31:0] seq_limit_cfg = prs_pkg::SEQ_LIMIT_RST;
  logic [31:0] next_seq = '0;
  logic [SHELF_DEPTH-1:0] shelf_busy = '0;
  logic [15:0] shelf_handle[SHELF_DEPTH];

  packet_resequencer u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic prs_pkg::out_pkt_t outcome(prs_pkg::status_t st, logic [31:0] s,
                                                logic [15:0] r);
    prs_pkg::out_pkt_t res;
    res.status = st;
    res.out_seq = s;
    res.out_ref = r;
    res.last = 1'b0;
    res.complete = (next_seq >= seq_limit_cfg);
    return res;
  endfunction

  function automatic void resequence(prs_pkg::in_pkt_t pkt);
    prs_pkg::out_pkt_t burst[SHELF_DEPTH];
    int n;
    int slot;
    logic [31:0] s;
    s = pkt.seq_num;
    n = 1;
    if (pkt.cmd == prs_pkg::CMD_START) begin
      shelf_busy = '0;
      next_seq = first_seq_cfg;
      burst[0] = outcome(prs_pkg::ST_STARTED, first_seq_cfg, '0);
    end else if (s < first_seq_cfg || s >= seq_limit_cfg) begin
      burst[0] = outcome(prs_pkg::ST_RANGE, s, '0);
    end else if (s < next_seq) begin
      burst[0] = outcome(prs_pkg::ST_DUP, s, '0);
    end else if (s == next_seq) begin
      next_seq = s + 1;
      burst[0] = outcome(prs_pkg::ST_RELEASED, s, pkt.payload_ref);
      // walk the shelf while consecutive packets are waiting
      while (n < SHELF_DEPTH && shelf_busy[next_seq % SHELF_DEPTH]) begin
        slot = next_seq % SHELF_DEPTH;
        shelf_busy[slot] = 1'b0;
        next_seq = next_seq + 1;
        burst[n] = outcome(prs_pkg::ST_RELEASED, next_seq - 1, shelf_handle[slot]);
        n = n + 1;
      end
    end else if (s - next_seq >= SHELF_DEPTH) begin
      burst[0] = outcome(prs_pkg::ST_OVERFLOW, s, '0);
    end else begin
      slot = s % SHELF_DEPTH;
      if (shelf_busy[slot]) begin
        burst[0] = outcome(prs_pkg::ST_DUP, s, '0);
      end else begin
        shelf_busy[slot] = 1'b1;
        shelf_handle[slot] = pkt.payload_ref;
        burst[0] = outcome(prs_pkg::ST_STASHED, s, '0);
      end
    end
    for (int i = 0; i < n; i++) begin
      burst[i].last = (i == n - 1);
      due_results = {due_results, burst[i]};
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_pkts.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_pkts.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with one long hold-off
  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    prs_pkg::out_pkt_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      resequence(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d seq %h",
               out_data.status, out_data.out_seq);
        errors = errors + 1;
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors = errors + 1;
        end
        if (out_data.out_seq !== want.out_seq) begin
          $error("out_seq: expected %h, got %h", want.out_seq, out_data.out_seq);
          errors = errors + 1;
        end
        if (out_data.out_ref !== want.out_ref) begin
          $error("out_ref: expected %h, got %h", want.out_ref, out_data.out_ref);
          errors = errors + 1;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          errors = errors + 1;
        end
        if (out_data.complete !== want.complete) begin
          $error("complete: expected %b, got %b", want.complete, out_data.complete);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_pkt(prs_pkg::cmd_t c, logic [31:0] s, logic [15:0] r);
    prs_pkg::in_pkt_t pkt;
    pkt.cmd = c;
    pkt.seq_num = s;
    pkt.payload_ref = r;
    pending_pkts = {pending_pkts, pkt};
    items_sent = items_sent + 1;
  endtask

  task automatic wait_idle();
    while (pending_pkts.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [prs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == prs_pkg::REG_FIRST_SEQ) begin
      first_seq_cfg = val;
    end else begin
      seq_limit_cfg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(logic [31:0] first, logic [31:0] limit);
    cfg_write(prs_pkg::REG_FIRST_SEQ, first);
    cfg_write(prs_pkg::REG_SEQ_LIMIT, limit);
  endtask

  task automatic run_session();
    logic [31:0] base;
    logic [31:0] f;
    logic restart;
    int len;
    int pos;
    int blk;
    int j;
    int tmp;
    int perm[SHELF_DEPTH];
    wait_idle();
    restart = 1'b1;
    f = $urandom_range(0, 2000);
    case ($urandom_range(0, 7))
      0, 1, 2: set_window(f, f + $urandom_range(8, 60));
      3: set_window('0, 32'hFFFF_FFFF);
      4: set_window(32'hFFFF_FFFF - $urandom_range(0, 40), 32'hFFFF_FFFF);
      5: begin
        f = $urandom();
        set_window(f, (f > 32'hFFFF_0000) ? 32'hFFFF_FFFF : f + $urandom_range(16, 400));
      end
      6: set_window($urandom_range(100, 300), $urandom_range(0, 99));
      default: begin
        // limit moved in mid session, shelf kept
        cfg_write(prs_pkg::REG_SEQ_LIMIT, next_seq + $urandom_range(4, 80));
        restart = 1'b0;
      end
    endcase
    if (restart) begin
      queue_pkt(prs_pkg::CMD_START, $urandom(), 16'($urandom()));
    end
    base = restart ? first_seq_cfg : next_seq;
    len = $urandom_range(6, 40);
    pos = 0;
    while (pos < len) begin
      blk = $urandom_range(1, SHELF_DEPTH);
      if (blk > len - pos) begin
        blk = len - pos;
      end
      for (int i = 0; i < blk; i++) begin
        perm[i] = i;
      end
      for (int i = blk - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      for (int i = 0; i < blk; i++) begin
        if ($urandom_range(99) < 12) begin
          case ($urandom_range(0, 9))
            0: queue_pkt(prs_pkg::CMD_START, $urandom(), 16'($urandom()));
            1, 2, 3: queue_pkt(prs_pkg::CMD_PACKET, $urandom(), 16'($urandom()));
            4, 5, 6: queue_pkt(prs_pkg::CMD_PACKET, base + pos - $urandom_range(0, 4),
                               16'($urandom()));
            default: queue_pkt(prs_pkg::CMD_PACKET,
                               base + pos + $urandom_range(SHELF_DEPTH, 3 * SHELF_DEPTH),
                               16'($urandom()));
          endcase
        end
        // an occasional lost packet leaves a gap in the stream
        if ($urandom_range(99) >= 3) begin
          queue_pkt(prs_pkg::CMD_PACKET, base + pos + perm[i], 16'($urandom()));
        end
      end
      pos = pos + blk;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings reject everything
    queue_pkt(prs_pkg::CMD_PACKET, 32'd1, 16'h1234);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd0, 16'hFFFF);
    wait_idle();
    set_window(32'd1, 32'd64);
    // packets ahead of any start command
    queue_pkt(prs_pkg::CMD_PACKET, 32'd3, 16'hA5A5);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd3, 16'h5A5A);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd20, 16'h0000);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd0, 16'h0001);
    queue_pkt(prs_pkg::CMD_START, 32'hFFFF_FFFF, 16'hFFFF);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd3, 16'h0003);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd1, 16'hFFFF);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd2, 16'h0000);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd2, 16'h0007);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd63, 16'h0008);
    queue_pkt(prs_pkg::CMD_PACKET, 32'd64, 16'h0009);
    queue_pkt(prs_pkg::CMD_PACKET, 32'hFFFF_FFFF, 16'h000A);
    for (int s = 5; s <= 10; s++) begin
      queue_pkt(prs_pkg::CMD_PACKET, s, 16'(s + 256));
    end
    queue_pkt(prs_pkg::CMD_PACKET, 32'd4, 16'hBEEF);

    while (items_sent < 110) begin
      run_session();
    end
    wait_idle();
    src_idle_pct = 59;
    snk_idle_pct = 23;
    while (items_sent < 210) begin
      run_session();
    end
    wait_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_armed = 1'b1;
    while (items_sent < 310) begin
      run_session();
    end

    wait_idle();
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/prs_pkg.sv
design/prs_shelf.sv
design/prs_ctrl.sv
design/packet_resequencer.sv
design/prs_checker.sv
test/tb_top.sv
